// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger implies a condition in the next cycle.
`define ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== hw/rtl/mtfcl_pkg.sv =====
// ----------------------------------------------------------------------------
// mtfcl_pkg
// Types and constants for the move-to-front colour list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtfcl_pkg;

  // List depth and derived widths
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int POS_W = 4;
  localparam int SEL_W = (IDX_W > POS_W) ? IDX_W : POS_W;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int OUT_CNT_W = 5;
  localparam int OUT_CNT_MAX = 31;

  typedef logic [23:0] colour_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic             add_en;
    colour_t          colour;
    logic [POS_W-1:0] rd_pos;
    count_t           count;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/mtfcl_if.sv =====
// ----------------------------------------------------------------------------
// mtfcl channel interfaces
// Valid/ready channels for commands and results of the colour list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mtfcl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [3:0] read_position;

  modport source (output valid, output cmd, output red, output green, output blue,
                  output read_position, input ready);
  modport sink (input valid, input cmd, input red, input green, input blue,
                input read_position, output ready);
endinterface

interface mtfcl_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] entry_count;
  logic       hit;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (output valid, output entry_count, output hit, output out_red,
                  output out_green, output out_blue, input ready);
  modport sink (input valid, input entry_count, input hit, input out_red,
                input out_green, input out_blue, output ready);
endinterface

// ===== hw/rtl/mtfcl_cell.sv =====
// ----------------------------------------------------------------------------
// mtfcl_cell
// One list slot: holds a colour, matches it, shifts from its neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtfcl_cell (
  input  logic                          clk,
  input  mtfcl_pkg::cell_ctrl_t         ctrl,
  input  logic [mtfcl_pkg::IDX_W-1:0]   cell_idx,
  input  mtfcl_pkg::colour_t            prev_entry,
  input  logic                          found_in,
  output logic                          found_out,
  input  mtfcl_pkg::colour_t            rd_in,
  output mtfcl_pkg::colour_t            rd_out,
  output mtfcl_pkg::colour_t            entry,
  output logic                          match
);
  import mtfcl_pkg::*;

  colour_t entry_r;
  colour_t entry_nxt;
  logic    occupied;
  logic    rd_sel;

  // Match only slots below the count
  assign occupied  = count_t'(cell_idx) < ctrl.count;
  assign match     = occupied && (entry_r == ctrl.colour);
  assign found_out = found_in | match;

  // Fold own entry into the read chain when selected
  assign rd_sel = SEL_W'(cell_idx) == SEL_W'(ctrl.rd_pos);
  assign rd_out = rd_in | (rd_sel ? entry_r : '0);

  // Shift from the neighbor while no match lies ahead, else hold
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.add_en && !found_in) begin
      entry_nxt = prev_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ===== hw/rtl/move_to_front_colour_list.sv =====
// ----------------------------------------------------------------------------
// move_to_front_colour_list
// Most-recently-used list of RGB colours built as a chain of cells.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// in_ch    in   cmd, red, green, blue, read_position
// out_ch   out  entry_count, hit, out_red, out_green, out_blue
//
// One item per cycle while out_ch does not stall: all cells compare and shift in the accept cycle.
// The result appears in the output register in the cycle after accept.
// Reset clears the count and the output valid; slot contents need no reset.
// A new item is taken while a result waits only if that result leaves now.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module move_to_front_colour_list (
  input  logic         clk,
  input  logic         rst_n,
  mtfcl_in_if.sink     in_ch,
  mtfcl_out_if.source  out_ch
);
  import mtfcl_pkg::*;

  logic        in_acc;
  cmd_t        cmd;
  colour_t     colour;
  count_t      held_count_r;
  count_t      held_count_nxt;
  cell_ctrl_t  ctrl;
  logic        found;
  logic        rd_hit;
  colour_t     rd_data;

  logic [MAX_ENTRIES:0]   found_chain;
  colour_t                rd_chain [MAX_ENTRIES+1];
  colour_t                entries [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] match_vec;

  logic                 out_valid_r;
  logic [OUT_CNT_W-1:0] out_count_r;
  logic [OUT_CNT_W-1:0] out_count_nxt;
  logic                 out_hit_r;
  logic                 out_hit_nxt;
  colour_t              out_colour_r;
  colour_t              out_colour_nxt;

  logic                 clear_acc;
  logic                 add_new;
  count_t               count_inc;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cmd         = cmd_t'(in_ch.cmd);
  assign colour      = {in_ch.red, in_ch.green, in_ch.blue};

  // Broadcast the command to the chain
  always_comb begin
    ctrl.add_en = in_acc && (cmd == CMD_ADD);
    ctrl.colour = colour;
    ctrl.rd_pos = in_ch.read_position;
    ctrl.count  = held_count_r;
  end

  // Chain of slots, front at index zero
  assign found_chain[0] = 1'b0;
  assign rd_chain[0]    = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    colour_t prev;
    if (i == 0) begin : g_front
      assign prev = colour;
    end else begin : g_rest
      assign prev = entries[i-1];
    end

    mtfcl_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cell_idx   (IDX_W'(i)),
      .prev_entry (prev),
      .found_in   (found_chain[i]),
      .found_out  (found_chain[i+1]),
      .rd_in      (rd_chain[i]),
      .rd_out     (rd_chain[i+1]),
      .entry      (entries[i]),
      .match      (match_vec[i])
    );
  end

  assign found   = found_chain[MAX_ENTRIES];
  assign rd_data = rd_chain[MAX_ENTRIES];
  assign rd_hit  = (CMP_W'(in_ch.read_position) < CMP_W'(held_count_r)) &&
                   (int'(in_ch.read_position) < MAX_ENTRIES);

  // Update the count
  always_comb begin
    held_count_nxt = held_count_r;
    if (in_acc) begin
      case (cmd)
        CMD_ADD: begin
          if (!found && (int'(held_count_r) < MAX_ENTRIES)) begin
            held_count_nxt = held_count_r + count_t'(1);
          end
        end
        CMD_CLEAR: held_count_nxt = '0;
        default:   held_count_nxt = held_count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_count_r <= '0;
    end else begin
      held_count_r <= held_count_nxt;
    end
  end

  // Form the result
  always_comb begin
    out_hit_nxt    = 1'b0;
    out_colour_nxt = '0;
    case (cmd)
      CMD_ADD: out_hit_nxt = found;
      CMD_READ: begin
        out_hit_nxt    = rd_hit;
        out_colour_nxt = rd_hit ? rd_data : '0;
      end
      default: out_hit_nxt = 1'b0;
    endcase
    if (int'(held_count_nxt) > OUT_CNT_MAX) begin
      out_count_nxt = OUT_CNT_W'(OUT_CNT_MAX);
    end else begin
      out_count_nxt = OUT_CNT_W'(held_count_nxt);
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_count_r  <= out_count_nxt;
      out_hit_r    <= out_hit_nxt;
      out_colour_r <= out_colour_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.out_red     = out_colour_r[23:16];
  assign out_ch.out_green   = out_colour_r[15:8];
  assign out_ch.out_blue    = out_colour_r[7:0];

  // Terms for the checks
  assign clear_acc = in_acc && (cmd == CMD_CLEAR);
  assign add_new   = ctrl.add_en && !found && (int'(held_count_r) < MAX_ENTRIES);
  assign count_inc = held_count_r + count_t'(1);

  // Checks
  `ASSERT_CLK(a_count_cap, int'(held_count_r) <= MAX_ENTRIES, "count exceeds depth")
  `ASSERT_CLK(a_no_dup, $onehot0(match_vec), "colour held in more than one slot")
  `ASSERT_NEXT(a_clear_empty, clear_acc, out_ch.entry_count == '0, "clear left entries")
  `ASSERT_NEXT(a_add_grow, add_new, held_count_r == $past(count_inc), "add did not grow list")

endmodule
